// ===== sv/rbst_pkg.sv =====
// Shared types and constants for the ray/box slab test pipeline.
// No dependencies; imported by every module of the block.
package rbst_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned NUM_AXES        = 3;

  // Per-axis side information that travels next to the divider lanes
  typedef struct packed {
    logic d_zero;   // direction component is zero (parallel slab)
    logic in_slab;  // origin lies within the slab, bounds inclusive
    logic d_neg;    // direction component is negative
    logic lo_neg;   // lo - origin is negative
    logic hi_neg;   // hi - origin is negative
  } axis_flags_t;

endpackage

// ===== sv/ray_box_slab_test_top.sv =====
// Top level of the ray/box slab test: prep stage, six divider lanes, reduce stages.
// Depends on rbst_pkg, rbst_prep, rbst_div_lane and rbst_reduce.
//
// Takes one ray/box word per cycle and returns one hit bit per word, in order.
// The pipeline has one prep stage, one register stage per quotient bit in the six
// restoring divider lanes (Q16.16 quotients by default), and two output stages.
// Throughput is one word per cycle; a stall on a valid output word freezes the whole
// pipeline, and in_stall_o follows it in the same cycle.
module ray_box_slab_test_top #(
  parameter int unsigned CoordWidth = rbst_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FracBits   = rbst_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [CoordWidth-1:0] origin_x_i,
  input  logic signed [CoordWidth-1:0] origin_y_i,
  input  logic signed [CoordWidth-1:0] origin_z_i,
  input  logic signed [CoordWidth-1:0] direction_x_i,
  input  logic signed [CoordWidth-1:0] direction_y_i,
  input  logic signed [CoordWidth-1:0] direction_z_i,
  input  logic signed [CoordWidth-1:0] box_lo_x_i,
  input  logic signed [CoordWidth-1:0] box_lo_y_i,
  input  logic signed [CoordWidth-1:0] box_lo_z_i,
  input  logic signed [CoordWidth-1:0] box_hi_x_i,
  input  logic signed [CoordWidth-1:0] box_hi_y_i,
  input  logic signed [CoordWidth-1:0] box_hi_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o
);
  import rbst_pkg::*;

  localparam int unsigned NumBits = CoordWidth + FracBits;
  localparam int unsigned Depth   = NumBits + 3;

  logic                  en;
  logic [Depth-1:0]      vld_q;
  logic signed [CoordWidth-1:0] org[NUM_AXES], dir[NUM_AXES], lo[NUM_AXES], hi[NUM_AXES];
  logic [CoordWidth-1:0] num_lo[NUM_AXES], num_hi[NUM_AXES], den[NUM_AXES];
  axis_flags_t           flags[NUM_AXES];
  axis_flags_t           fl_q[NumBits][NUM_AXES];
  logic [CoordWidth-1:0] q_lo[NUM_AXES], q_hi[NUM_AXES];
  logic                  ovf_lo[NUM_AXES], ovf_hi[NUM_AXES];

  // Hold every stage while a finished word waits downstream
  assign en          = !(vld_q[Depth-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  assign org = '{origin_x_i, origin_y_i, origin_z_i};
  assign dir = '{direction_x_i, direction_y_i, direction_z_i};
  assign lo  = '{box_lo_x_i, box_lo_y_i, box_lo_z_i};
  assign hi  = '{box_hi_x_i, box_hi_y_i, box_hi_z_i};

  rbst_prep #(.CoordWidth(CoordWidth)) u_prep (
    .clk_i   (clk_i),
    .en_i    (en),
    .org_i   (org),
    .dir_i   (dir),
    .lo_i    (lo),
    .hi_i    (hi),
    .num_lo_o(num_lo),
    .num_hi_o(num_hi),
    .den_o   (den),
    .flags_o (flags)
  );

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    rbst_div_lane #(.CoordWidth(CoordWidth), .FracBits(FracBits)) u_div_lo (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_lo[a]),
      .den_i (den[a]),
      .quot_o(q_lo[a]),
      .ovf_o (ovf_lo[a])
    );
    rbst_div_lane #(.CoordWidth(CoordWidth), .FracBits(FracBits)) u_div_hi (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_hi[a]),
      .den_i (den[a]),
      .quot_o(q_hi[a]),
      .ovf_o (ovf_hi[a])
    );
  end

  // Delay the axis flags alongside the divider stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_q[0] <= flags;
      for (int s = 1; s < NumBits; s++) begin
        fl_q[s] <= fl_q[s-1];
      end
    end
  end

  rbst_reduce #(.CoordWidth(CoordWidth)) u_reduce (
    .clk_i   (clk_i),
    .en_i    (en),
    .q_lo_i  (q_lo),
    .ovf_lo_i(ovf_lo),
    .q_hi_i  (q_hi),
    .ovf_hi_i(ovf_hi),
    .flags_i (fl_q[NumBits-1]),
    .hit_o   (hit_o)
  );

endmodule

// ===== sv/rbst_prep.sv =====
// Input stage: corner-minus-origin magnitudes, direction magnitude and axis flags.
// Depends on rbst_pkg.
module rbst_prep #(
  parameter int unsigned CoordWidth = rbst_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [CoordWidth-1:0]         org_i   [rbst_pkg::NUM_AXES],
  input  logic signed [CoordWidth-1:0]         dir_i   [rbst_pkg::NUM_AXES],
  input  logic signed [CoordWidth-1:0]         lo_i    [rbst_pkg::NUM_AXES],
  input  logic signed [CoordWidth-1:0]         hi_i    [rbst_pkg::NUM_AXES],
  output logic        [CoordWidth-1:0]         num_lo_o[rbst_pkg::NUM_AXES],
  output logic        [CoordWidth-1:0]         num_hi_o[rbst_pkg::NUM_AXES],
  output logic        [CoordWidth-1:0]         den_o   [rbst_pkg::NUM_AXES],
  output rbst_pkg::axis_flags_t                flags_o [rbst_pkg::NUM_AXES]
);
  import rbst_pkg::*;

  logic [CoordWidth-1:0] num_lo_q[NUM_AXES], num_hi_q[NUM_AXES], den_q[NUM_AXES];
  axis_flags_t           flags_q [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    logic signed [CoordWidth:0] dlo, dhi;
    logic        [CoordWidth:0] mlo, mhi, mdir;
    axis_flags_t                fl;

    // Exact differences, one bit wider than a coordinate
    always_comb begin
      dlo  = {lo_i[a][CoordWidth-1], lo_i[a]} - {org_i[a][CoordWidth-1], org_i[a]};
      dhi  = {hi_i[a][CoordWidth-1], hi_i[a]} - {org_i[a][CoordWidth-1], org_i[a]};
      mlo  = dlo[CoordWidth] ? (~dlo + 1'b1) : dlo;
      mhi  = dhi[CoordWidth] ? (~dhi + 1'b1) : dhi;
      mdir = dir_i[a][CoordWidth-1] ? (~{1'b1, dir_i[a]} + 1'b1) : {1'b0, dir_i[a]};
      fl.d_zero  = (dir_i[a] == '0);
      fl.in_slab = (lo_i[a] <= org_i[a]) && (org_i[a] <= hi_i[a]);
      fl.d_neg   = dir_i[a][CoordWidth-1];
      fl.lo_neg  = dlo[CoordWidth];
      fl.hi_neg  = dhi[CoordWidth];
    end

    // Capture on advance
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_lo_q[a] <= mlo[CoordWidth-1:0];
        num_hi_q[a] <= mhi[CoordWidth-1:0];
        den_q[a]    <= mdir[CoordWidth-1:0];
        flags_q[a]  <= fl;
      end
    end
  end

  assign num_lo_o = num_lo_q;
  assign num_hi_o = num_hi_q;
  assign den_o    = den_q;
  assign flags_o  = flags_q;

endmodule

// ===== sv/rbst_div_lane.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
// Computes (num * 2^FracBits) / den unsigned; depends on rbst_pkg for defaults.
module rbst_div_lane #(
  parameter int unsigned CoordWidth = rbst_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FracBits   = rbst_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [CoordWidth-1:0] num_i,
  input  logic [CoordWidth-1:0] den_i,
  output logic [CoordWidth-1:0] quot_o,
  output logic                  ovf_o
);
  import rbst_pkg::*;

  localparam int unsigned NumBits = CoordWidth + FracBits;

  logic [NumBits-1:0]    n_q  [NumBits];
  logic [CoordWidth-1:0] r_q  [NumBits];
  logic [CoordWidth-1:0] d_q  [NumBits];
  logic [CoordWidth-1:0] q_q  [NumBits];
  logic                  ovf_q[NumBits];

  for (genvar s = 0; s < NumBits; s++) begin : g_step
    logic [NumBits-1:0]    n_prev;
    logic [CoordWidth-1:0] r_prev, d_prev, q_prev;
    logic                  ovf_prev;
    logic [CoordWidth:0]   r_sh, r_nx;
    logic                  ge;

    // Select what this step works on
    if (s == 0) begin : g_first
      assign n_prev   = NumBits'(num_i) << FracBits;
      assign r_prev   = '0;
      assign d_prev   = den_i;
      assign q_prev   = '0;
      assign ovf_prev = 1'b0;
    end else begin : g_next
      assign n_prev   = n_q[s-1];
      assign r_prev   = r_q[s-1];
      assign d_prev   = d_q[s-1];
      assign q_prev   = q_q[s-1];
      assign ovf_prev = ovf_q[s-1];
    end

    // Shift in one numerator bit, compare and subtract
    always_comb begin
      r_sh = {r_prev, n_prev[NumBits-1]};
      ge   = (r_sh >= {1'b0, d_prev});
      r_nx = ge ? (r_sh - {1'b0, d_prev}) : r_sh;
    end

    // Advance the stage; quotient bits shifted out of range mark overflow
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s]   <= n_prev << 1;
        r_q[s]   <= r_nx[CoordWidth-1:0];
        d_q[s]   <= d_prev;
        q_q[s]   <= {q_prev[CoordWidth-2:0], ge};
        ovf_q[s] <= ovf_prev | q_prev[CoordWidth-1];
      end
    end
  end

  assign quot_o = q_q[NumBits-1];
  assign ovf_o  = ovf_q[NumBits-1];

endmodule

// ===== sv/rbst_reduce.sv =====
// Output stages: saturate and sign quotients, order slab ends, then min/max and hit.
// Depends on rbst_pkg.
module rbst_reduce #(
  parameter int unsigned CoordWidth = rbst_pkg::COORD_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [CoordWidth-1:0] q_lo_i  [rbst_pkg::NUM_AXES],
  input  logic                  ovf_lo_i[rbst_pkg::NUM_AXES],
  input  logic [CoordWidth-1:0] q_hi_i  [rbst_pkg::NUM_AXES],
  input  logic                  ovf_hi_i[rbst_pkg::NUM_AXES],
  input  rbst_pkg::axis_flags_t flags_i [rbst_pkg::NUM_AXES],
  output logic                  hit_o
);
  import rbst_pkg::*;

  localparam logic [CoordWidth-1:0] MostNeg = {1'b1, {(CoordWidth-1){1'b0}}};
  localparam logic [CoordWidth-1:0] MostPos = ~MostNeg;

  function automatic logic signed [CoordWidth-1:0] sat_quot(
    input logic [CoordWidth-1:0] q, input logic ovf, input logic neg);
    logic [CoordWidth-1:0] lim;
    logic [CoordWidth-1:0] mag;
    lim = neg ? MostNeg : MostPos;
    mag = (ovf || (q > lim)) ? lim : q;
    return neg ? $signed(-mag) : $signed(mag);
  endfunction

  logic signed [CoordWidth-1:0] t0_q[NUM_AXES], t1_q[NUM_AXES];
  logic                         empty_q;
  logic                         hit_q;
  logic [NUM_AXES-1:0]          empty_ax;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    logic signed [CoordWidth-1:0] ql, qh, t0, t1;

    // Swap ends when the direction is negative; parallel slab is all or nothing
    always_comb begin
      ql = sat_quot(q_lo_i[a], ovf_lo_i[a], flags_i[a].lo_neg ^ flags_i[a].d_neg);
      qh = sat_quot(q_hi_i[a], ovf_hi_i[a], flags_i[a].hi_neg ^ flags_i[a].d_neg);
      empty_ax[a] = flags_i[a].d_zero && !flags_i[a].in_slab;
      if (flags_i[a].d_zero) begin
        t0 = flags_i[a].in_slab ? $signed(MostNeg) : $signed(MostPos);
        t1 = flags_i[a].in_slab ? $signed(MostPos) : $signed(MostNeg);
      end else if (flags_i[a].d_neg) begin
        t0 = qh;
        t1 = ql;
      end else begin
        t0 = ql;
        t1 = qh;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t0_q[a] <= t0;
        t1_q[a] <= t1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      empty_q <= |empty_ax;
    end
  end

  // Entry is the latest start, exit the earliest end
  logic signed [CoordWidth-1:0] t_min, t_max;
  always_comb begin
    t_min = t0_q[0];
    t_max = t1_q[0];
    for (int a = 1; a < NUM_AXES; a++) begin
      if (t0_q[a] > t_min) t_min = t0_q[a];
      if (t1_q[a] < t_max) t_max = t1_q[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= !empty_q && !(t_min > t_max) && !t_max[CoordWidth-1];
    end
  end

  assign hit_o = hit_q;

endmodule

// ===== sv/rbst_checker.sv =====
// Port-level checks for the ray/box slab test, bound to the top level.
// Depends only on the top level's ports.
module rbst_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic hit_o
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o))
    else $error("result word changed under stall");

  // Input stalls only while a finished word is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Output backpressure on a valid word always reaches the input
  a_stall_prop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while pipeline frozen");

endmodule

bind ray_box_slab_test_top rbst_checker u_rbst_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .hit_o      (hit_o)
);
